// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is held.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Clocked invariant check, disabled while reset is held.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ===== design/atrp_pkg.sv =====
`timescale 1ns / 1ps
package atrp_pkg;

  localparam int IN_W         = 16;
  localparam int WINDOW       = 5;
  localparam int CORDIC_STEPS = 20;
  localparam int AXES         = 3;
  localparam int AX_X         = 0;
  localparam int AX_Y         = 1;
  localparam int AX_Z         = 2;

  localparam int SUM_W  = IN_W + $clog2(WINDOW);
  localparam int SQ_W   = 2 * SUM_W;
  localparam int RR_W   = SQ_W + 1;
  localparam int K_W    = 5;
  localparam int K_MAX  = 30;
  localparam int LIM_EXP = 58;

  localparam int OP_W   = 32;
  localparam int CW     = OP_W + 2;
  localparam int ZW     = 27;
  localparam int FRAC   = 16;
  localparam int STEP_W = 5;

  localparam int RAD_W      = 62;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

  localparam int ROLL_W  = 9;
  localparam int PITCH_W = 8;
  localparam int DEG_W   = ZW - FRAC;

  localparam int IN_TDATA_W  = ((AXES * IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ROLL_W + PITCH_W + 7) / 8) * 8;

  localparam logic signed [ZW-1:0] Z_45  = ZW'(45 << FRAC);
  localparam logic signed [ZW-1:0] Z_90  = ZW'(90 << FRAC);
  localparam logic signed [ZW-1:0] Z_135 = ZW'(135 << FRAC);
  localparam logic signed [ZW-1:0] Z_180 = ZW'(180 << FRAC);

  typedef struct packed {
    logic load;
    logic sq_en;
    logic sum_en;
    logic norm_en;
    logic cordic_start;
    logic cordic_pitch;
    logic sqrt_start;
    logic out_load;
  } atrp_cmd_t;

  typedef struct packed {
    logic cordic_busy;
    logic sqrt_busy;
  } atrp_sts_t;

  typedef struct packed {
    logic signed [OP_W-1:0] ys;
    logic signed [OP_W-1:0] xs;
    logic                   y_zero;
    logic                   x_zero;
    logic                   equal;
  } atrp_op_t;

  // atan(2^-i) in degrees, 16 fractional bits, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q16(logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] a;
    unique case (i)
      5'd0:    a = ZW'(2949120);
      5'd1:    a = ZW'(1740967);
      5'd2:    a = ZW'(919879);
      5'd3:    a = ZW'(466945);
      5'd4:    a = ZW'(234379);
      5'd5:    a = ZW'(117304);
      5'd6:    a = ZW'(58666);
      5'd7:    a = ZW'(29335);
      5'd8:    a = ZW'(14668);
      5'd9:    a = ZW'(7334);
      5'd10:   a = ZW'(3667);
      5'd11:   a = ZW'(1833);
      5'd12:   a = ZW'(917);
      5'd13:   a = ZW'(458);
      5'd14:   a = ZW'(229);
      5'd15:   a = ZW'(115);
      5'd16:   a = ZW'(57);
      5'd17:   a = ZW'(29);
      5'd18:   a = ZW'(14);
      5'd19:   a = ZW'(7);
      5'd20:   a = ZW'(4);
      5'd21:   a = ZW'(2);
      5'd22:   a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // largest k <= K_MAX with m <= 2^(LIM_EXP - 2k + 2) at every step taken
  function automatic logic [K_W-1:0] norm_shift(logic [RR_W-1:0] m);
    logic [K_W-1:0] k;
    k = K_W'(K_MAX);
    for (int j = K_MAX - 1; j >= 0; j--) begin
      if ({{(64 - RR_W){1'b0}}, m} > (64'd1 << (LIM_EXP - 2 * j))) begin
        k = K_W'(j);
      end
    end
    return k;
  endfunction

endpackage

// ===== design/atrp_sqrt.sv =====
`timescale 1ns / 1ps
module atrp_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [atrp_pkg::RAD_W-1:0]   radicand,
  output logic                         busy,
  output logic [atrp_pkg::ROOT_W-1:0]  root
);

  logic [atrp_pkg::RAD_W-1:0]      rem_r, rem_nxt;
  logic [atrp_pkg::RAD_W-1:0]      res_r, res_nxt;
  logic [atrp_pkg::RAD_W-1:0]      bit_r, bit_nxt;
  logic [atrp_pkg::RAD_W-1:0]      trial;
  logic [atrp_pkg::SQRT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;

  assign trial = res_r + bit_r;

  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = radicand;
      res_nxt  = '0;
      bit_nxt  = atrp_pkg::RAD_W'(1) << (atrp_pkg::RAD_W - 2);
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == atrp_pkg::SQRT_CNT_W'(atrp_pkg::SQRT_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[atrp_pkg::ROOT_W-1:0];

endmodule

// ===== design/atrp_cordic.sv =====
`timescale 1ns / 1ps
module atrp_cordic (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  atrp_pkg::atrp_op_t              op,
  output logic                            busy,
  output logic signed [atrp_pkg::ZW-1:0]  z
);

  logic signed [atrp_pkg::CW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [atrp_pkg::CW-1:0]  dx, dy, xs_e, ys_e;
  logic signed [atrp_pkg::ZW-1:0]  z_r, z_nxt, ang;
  logic [atrp_pkg::STEP_W-1:0]     cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic                            xs_neg, ys_pos, y_pos;

  assign xs_e   = atrp_pkg::CW'(op.xs);
  assign ys_e   = atrp_pkg::CW'(op.ys);
  assign xs_neg = op.xs[atrp_pkg::OP_W-1];
  assign ys_pos = !op.ys[atrp_pkg::OP_W-1] && (op.ys != '0);
  assign y_pos  = !y_r[atrp_pkg::CW-1] && (y_r != '0);
  assign dx     = y_r >>> cnt_r;
  assign dy     = x_r >>> cnt_r;
  assign ang    = atrp_pkg::atan_q16(cnt_r);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      cnt_nxt  = '0;
      x_nxt    = xs_e;
      y_nxt    = ys_e;
      busy_nxt = 1'b0;
      priority if (op.y_zero) begin
        z_nxt = xs_neg ? atrp_pkg::Z_180 : '0;
      end else if (op.x_zero) begin
        z_nxt = ys_pos ? atrp_pkg::Z_90 : -atrp_pkg::Z_90;
      end else if (op.equal) begin
        if (!xs_neg) begin
          z_nxt = ys_pos ? atrp_pkg::Z_45 : -atrp_pkg::Z_45;
        end else begin
          z_nxt = ys_pos ? atrp_pkg::Z_135 : -atrp_pkg::Z_135;
        end
      end else begin
        busy_nxt = 1'b1;
        if (xs_neg) begin
          // fold the left half plane over, start from +-180
          z_nxt = ys_pos ? atrp_pkg::Z_180 : -atrp_pkg::Z_180;
          x_nxt = -xs_e;
          y_nxt = -ys_e;
        end else begin
          z_nxt = '0;
        end
      end
    end else if (busy_r) begin
      if (y_pos) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + ang;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - ang;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == atrp_pkg::STEP_W'(atrp_pkg::CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign busy = busy_r;
  assign z    = z_r;

endmodule

// ===== design/atrp_dp.sv =====
`timescale 1ns / 1ps
module atrp_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  atrp_pkg::atrp_cmd_t                  cmd,
  input  logic signed [atrp_pkg::IN_W-1:0]     accel_x,
  input  logic signed [atrp_pkg::IN_W-1:0]     accel_y,
  input  logic signed [atrp_pkg::IN_W-1:0]     accel_z,
  output atrp_pkg::atrp_sts_t                  sts,
  output logic signed [atrp_pkg::ROLL_W-1:0]   roll_deg,
  output logic signed [atrp_pkg::PITCH_W-1:0]  pitch_deg
);

  logic signed [atrp_pkg::IN_W-1:0]    sample [atrp_pkg::AXES];
  logic signed [atrp_pkg::IN_W-1:0]    hist_r [atrp_pkg::AXES][atrp_pkg::WINDOW];
  logic signed [atrp_pkg::SUM_W-1:0]   sum_r  [atrp_pkg::AXES];
  logic [atrp_pkg::SUM_W-1:0]          mag    [atrp_pkg::AXES];
  logic [atrp_pkg::SQ_W-1:0]           sq_r   [atrp_pkg::AXES];
  logic [atrp_pkg::RR_W-1:0]           rr_r;
  logic [atrp_pkg::RR_W-1:0]           yy_e, zz_e, xx_e;
  logic [atrp_pkg::K_W-1:0]            k_roll_r, k_pitch_r;
  logic [atrp_pkg::RAD_W-1:0]          radicand;
  logic [atrp_pkg::ROOT_W-1:0]         root;
  atrp_pkg::atrp_op_t                  op;
  logic signed [atrp_pkg::ZW-1:0]      z;
  logic signed [atrp_pkg::DEG_W-1:0]   z_deg;
  logic signed [atrp_pkg::ROLL_W-1:0]  roll_r, out_roll_r;
  logic signed [atrp_pkg::PITCH_W-1:0] out_pitch_r;
  logic                                cordic_busy, sqrt_busy;

  function automatic logic [atrp_pkg::SUM_W-1:0] abs_mag(
    logic signed [atrp_pkg::SUM_W-1:0] v
  );
    return v[atrp_pkg::SUM_W-1] ? atrp_pkg::SUM_W'(-v) : atrp_pkg::SUM_W'(v);
  endfunction

  function automatic logic signed [atrp_pkg::DEG_W-1:0] trunc_deg(
    logic signed [atrp_pkg::ZW-1:0] a
  );
    logic [atrp_pkg::ZW-1:0]    m;
    logic [atrp_pkg::DEG_W-1:0] d;
    m = a[atrp_pkg::ZW-1] ? atrp_pkg::ZW'(-a) : atrp_pkg::ZW'(a);
    d = m[atrp_pkg::ZW-1:atrp_pkg::FRAC];
    return a[atrp_pkg::ZW-1] ? -d : d;
  endfunction

  assign sample[atrp_pkg::AX_X] = accel_x;
  assign sample[atrp_pkg::AX_Y] = accel_y;
  assign sample[atrp_pkg::AX_Z] = accel_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < atrp_pkg::AXES; a++) begin
        for (int w = 0; w < atrp_pkg::WINDOW; w++) begin
          hist_r[a][w] <= '0;
        end
        sum_r[a] <= '0;
      end
    end else if (cmd.load) begin
      for (int a = 0; a < atrp_pkg::AXES; a++) begin
        for (int w = 1; w < atrp_pkg::WINDOW; w++) begin
          hist_r[a][w-1] <= hist_r[a][w];
        end
        hist_r[a][atrp_pkg::WINDOW-1] <= sample[a];
        sum_r[a] <= sum_r[a] - atrp_pkg::SUM_W'(hist_r[a][0])
                    + atrp_pkg::SUM_W'(sample[a]);
      end
    end
  end

  always_comb begin
    for (int a = 0; a < atrp_pkg::AXES; a++) begin
      mag[a] = abs_mag(sum_r[a]);
    end
  end

  assign xx_e = atrp_pkg::RR_W'(sq_r[atrp_pkg::AX_X]);
  assign yy_e = atrp_pkg::RR_W'(sq_r[atrp_pkg::AX_Y]);
  assign zz_e = atrp_pkg::RR_W'(sq_r[atrp_pkg::AX_Z]);

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      for (int a = 0; a < atrp_pkg::AXES; a++) begin
        sq_r[a] <= mag[a] * mag[a];
      end
    end
    if (cmd.sum_en) begin
      rr_r     <= yy_e + zz_e;
      k_roll_r <= atrp_pkg::norm_shift((yy_e > zz_e) ? yy_e : zz_e);
    end
    if (cmd.norm_en) begin
      k_pitch_r <= atrp_pkg::norm_shift((xx_e > rr_r) ? xx_e : rr_r);
    end
  end

  assign radicand = atrp_pkg::RAD_W'(rr_r) << {k_pitch_r, 1'b0};

  always_comb begin
    if (cmd.cordic_pitch) begin
      op.ys     = (-atrp_pkg::OP_W'(sum_r[atrp_pkg::AX_X])) <<< k_pitch_r;
      op.xs     = atrp_pkg::OP_W'(root);
      op.y_zero = (sum_r[atrp_pkg::AX_X] == '0);
      op.x_zero = (rr_r == '0);
      op.equal  = (xx_e == rr_r);
    end else begin
      op.ys     = atrp_pkg::OP_W'(sum_r[atrp_pkg::AX_Y]) <<< k_roll_r;
      op.xs     = atrp_pkg::OP_W'(sum_r[atrp_pkg::AX_Z]) <<< k_roll_r;
      op.y_zero = (sum_r[atrp_pkg::AX_Y] == '0);
      op.x_zero = (sum_r[atrp_pkg::AX_Z] == '0);
      op.equal  = (yy_e == zz_e);
    end
  end

  atrp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (radicand),
    .busy     (sqrt_busy),
    .root     (root)
  );

  atrp_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cordic_start),
    .op    (op),
    .busy  (cordic_busy),
    .z     (z)
  );

  assign z_deg = trunc_deg(z);

  always_ff @(posedge clk) begin
    if (cmd.cordic_start && cmd.cordic_pitch) begin
      roll_r <= atrp_pkg::ROLL_W'(z_deg);
    end
    if (cmd.out_load) begin
      out_roll_r  <= roll_r;
      out_pitch_r <= atrp_pkg::PITCH_W'(z_deg);
    end
  end

  assign sts.cordic_busy = cordic_busy;
  assign sts.sqrt_busy   = sqrt_busy;
  assign roll_deg        = out_roll_r;
  assign pitch_deg       = out_pitch_r;

endmodule

// ===== design/atrp_ctrl.sv =====
`timescale 1ns / 1ps
module atrp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  atrp_pkg::atrp_sts_t  sts,
  output atrp_pkg::atrp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQR   = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_NORM  = 3'd3;
  localparam logic [2:0] S_SQST  = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_PWAIT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       out_free;

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_NORM;
      end
      S_NORM: begin
        cmd.norm_en      = 1'b1;
        cmd.cordic_start = 1'b1;
        state_nxt        = S_SQST;
      end
      S_SQST: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_WAIT;
      end
      S_WAIT: begin
        if (!sts.cordic_busy && !sts.sqrt_busy) begin
          cmd.cordic_start = 1'b1;
          cmd.cordic_pitch = 1'b1;
          state_nxt        = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (!sts.cordic_busy && out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

// ===== design/accel_tilt_roll_pitch.sv =====
// Flow: each sample is loaded, squared, summed and normalised; the roll CORDIC pass
// then overlaps the 31-step square root, and the 20-step pitch CORDIC pass follows in
// series. A new sample is accepted only after the previous result has been loaded
// into the output register, which waits while an earlier result is still held there.
// Reset: synchronous, active-low rst_n clears the sample histories, window sums,
// controller state and the output valid flag.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module accel_tilt_roll_pitch (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic [atrp_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // roll_deg [8:0], pitch_deg [16:9], zero fill [23:17]
  output logic [atrp_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  atrp_pkg::atrp_cmd_t                  cmd;
  atrp_pkg::atrp_sts_t                  sts;
  logic signed [atrp_pkg::IN_W-1:0]     accel_x, accel_y, accel_z;
  logic signed [atrp_pkg::ROLL_W-1:0]   roll_deg;
  logic signed [atrp_pkg::PITCH_W-1:0]  pitch_deg;

  assign accel_x = in_tdata[atrp_pkg::IN_W-1:0];
  assign accel_y = in_tdata[2*atrp_pkg::IN_W-1:atrp_pkg::IN_W];
  assign accel_z = in_tdata[3*atrp_pkg::IN_W-1:2*atrp_pkg::IN_W];

  atrp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  atrp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .sts       (sts),
    .roll_deg  (roll_deg),
    .pitch_deg (pitch_deg)
  );

  assign out_tdata = {{(atrp_pkg::OUT_TDATA_W - atrp_pkg::ROLL_W - atrp_pkg::PITCH_W){1'b0}},
                      pitch_deg, roll_deg};

  `ASSERT_IMPL(a_accept_units_idle, in_tvalid && in_tready, !sts.cordic_busy && !sts.sqrt_busy, "sample transfer while an iterative unit is busy")
  `ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_tvalid || out_tready, "result register overwritten before transfer")
  `ASSERT_IMPL(a_cordic_start_idle, cmd.cordic_start, !sts.cordic_busy, "CORDIC restarted while busy")
  `ASSERT_IMPL(a_pitch_after_root, cmd.cordic_start && cmd.cordic_pitch, !sts.sqrt_busy, "pitch pass started before the root is done")
  `ASSERT_ALWAYS(a_sqrt_start_idle, !(cmd.sqrt_start && sts.sqrt_busy), "square root restarted while busy")

endmodule
